// ===== hw/rtl/ccp_pkg.sv =====
// Shared types and constants for the compressor cycle protection controller.
// No dependencies; every other file of the block imports this package.
package ccp_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int TEMP_W     = 16;
	localparam int TIME_W     = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ON_THR     = 3'd0;
	localparam cfg_idx_t REG_OFF_THR    = 3'd1;
	localparam cfg_idx_t REG_WORK_TICKS = 3'd2;
	localparam cfg_idx_t REG_WAIT_TICKS = 3'd3;
	localparam cfg_idx_t REG_REST_TICKS = 3'd4;

	localparam logic MODE_TICK    = 1'b0;
	localparam logic MODE_READING = 1'b1;

	// Internal controller state, one-hot.
	typedef enum logic [3:0] {
		S_READY = 4'b0001,
		S_REST  = 4'b0010,
		S_WORK  = 4'b0100,
		S_WAIT  = 4'b1000
	} ctrl_st_t;

	// State code as reported on the result channel.
	typedef logic [1:0] st_code_t;

	localparam st_code_t ST_CODE_READY = 2'd0;
	localparam st_code_t ST_CODE_REST  = 2'd1;
	localparam st_code_t ST_CODE_WORK  = 2'd2;
	localparam st_code_t ST_CODE_WAIT  = 2'd3;

	typedef logic [1:0] pwr_ev_t;

	localparam pwr_ev_t EV_NONE  = 2'd0;
	localparam pwr_ev_t EV_START = 2'd1;
	localparam pwr_ev_t EV_STOP  = 2'd2;

	typedef struct packed {
		logic signed [TEMP_W-1:0] on_thr;
		logic signed [TEMP_W-1:0] off_thr;
		logic [TIME_W-1:0]        work_ticks;
		logic [TIME_W-1:0]        wait_ticks;
		logic [TIME_W-1:0]        rest_ticks;
	} cfg_t;

	typedef struct packed {
		logic                     mode;
		logic signed [TEMP_W-1:0] temperature;
		logic                     sensor_fault;
	} item_t;

	typedef struct packed {
		logic     compressor_on;
		st_code_t ctrl_state;
		logic     request_temp;
		pwr_ev_t  power_event;
	} result_t;

	function automatic st_code_t state_code(ctrl_st_t s);
		st_code_t c;
		unique case (s)
			S_READY: c = ST_CODE_READY;
			S_REST:  c = ST_CODE_REST;
			S_WORK:  c = ST_CODE_WORK;
			S_WAIT:  c = ST_CODE_WAIT;
			default: c = ST_CODE_READY;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/ccp_if.sv =====
// Valid/ready channel interfaces for readings and ticks in, and results out.
// Depends on ccp_pkg for field widths and codes.
interface ccp_item_if
	import ccp_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic signed [TEMP_W-1:0] temperature;
	logic                     sensor_fault;

	modport source(output valid, mode, temperature, sensor_fault, input ready);
	modport sink(input valid, mode, temperature, sensor_fault, output ready);
endinterface

interface ccp_result_if
	import ccp_pkg::*;
();
	logic     valid;
	logic     ready;
	logic     compressor_on;
	st_code_t ctrl_state;
	logic     request_temp;
	pwr_ev_t  power_event;

	modport source(output valid, compressor_on, ctrl_state, request_temp, power_event,
		input ready);
	modport sink(input valid, compressor_on, ctrl_state, request_temp, power_event,
		output ready);
endinterface

// ===== hw/rtl/ccp_cfg_regs.sv =====
// Configuration register file: thresholds and the three timer loads.
// Depends on ccp_pkg for the register indexes and the cfg_t bundle.
module ccp_cfg_regs
	import ccp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_thr     <= 16'sd40;
			cfg_q.off_thr    <= 16'sd10;
			cfg_q.work_ticks <= 32'd36000;
			cfg_q.wait_ticks <= 32'd3000;
			cfg_q.rest_ticks <= 32'd6000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ON_THR:     cfg_q.on_thr     <= cfg_data[TEMP_W-1:0];
				REG_OFF_THR:    cfg_q.off_thr    <= cfg_data[TEMP_W-1:0];
				REG_WORK_TICKS: cfg_q.work_ticks <= cfg_data[TIME_W-1:0];
				REG_WAIT_TICKS: cfg_q.wait_ticks <= cfg_data[TIME_W-1:0];
				REG_REST_TICKS: cfg_q.rest_ticks <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ccp_step.sv =====
// Next-state logic for one transaction: state transition, timer load or
// decrement, and the result fields. Depends on ccp_pkg.
module ccp_step
	import ccp_pkg::*;
#(
	parameter int TIMER_WIDTH = 32
) (
	input  ctrl_st_t               st,
	input  logic [TIMER_WIDTH-1:0] ticks,
	input  logic                   startup,
	input  item_t                  item,
	input  cfg_t                   cfg,
	output ctrl_st_t               nxt_st,
	output logic [TIMER_WIDTH-1:0] nxt_ticks,
	output result_t                res
);

	logic              load_en;
	logic              clr_ticks;
	logic [TIME_W-1:0] load_sel;
	logic [TIMER_WIDTH-1:0] load_val;
	logic              req;
	pwr_ev_t           ev;
	logic              ticks_le1;
	logic              ge_on;
	logic              le_off;

	assign ticks_le1 = (ticks[TIMER_WIDTH-1:1] == '0);
	assign ge_on     = (item.temperature >= cfg.on_thr);
	assign le_off    = (item.temperature <= cfg.off_thr);

	// A load wider than the counter saturates to the counter's full scale.
	generate
		if (TIMER_WIDTH >= TIME_W) begin : g_wide
			assign load_val = TIMER_WIDTH'(load_sel);
		end else begin : g_narrow
			assign load_val = (|load_sel[TIME_W-1:TIMER_WIDTH]) ? '1
				: load_sel[TIMER_WIDTH-1:0];
		end
	endgenerate

	always_comb begin
		nxt_st    = st;
		load_en   = 1'b0;
		clr_ticks = 1'b0;
		load_sel  = cfg.wait_ticks;
		req       = 1'b0;
		ev        = EV_NONE;
		if (item.mode == MODE_TICK) begin
			if (st != S_READY && ticks_le1) begin
				if (st == S_WORK) begin
					nxt_st   = S_REST;
					load_en  = 1'b1;
					load_sel = cfg.rest_ticks;
					ev       = EV_STOP;
				end else begin
					nxt_st    = S_READY;
					clr_ticks = 1'b1;
					req       = 1'b1;
				end
			end
		end else if (item.sensor_fault) begin
			// A fault wins over both thresholds but only matters while working.
			if (st == S_WORK) begin
				nxt_st  = S_WAIT;
				load_en = 1'b1;
				ev      = EV_STOP;
			end
		end else if (ge_on && st == S_READY) begin
			nxt_st   = S_WORK;
			load_en  = 1'b1;
			load_sel = cfg.work_ticks;
			ev       = EV_START;
		end else if (le_off && st == S_WORK) begin
			nxt_st  = S_WAIT;
			load_en = 1'b1;
			ev      = EV_STOP;
		end
	end

	always_comb begin
		if (load_en) begin
			nxt_ticks = load_val;
		end else if (clr_ticks) begin
			nxt_ticks = '0;
		end else if (item.mode == MODE_TICK && st != S_READY) begin
			nxt_ticks = ticks - TIMER_WIDTH'(1);
		end else begin
			nxt_ticks = ticks;
		end
	end

	assign res.compressor_on = (nxt_st == S_WORK);
	assign res.ctrl_state    = state_code(nxt_st);
	assign res.request_temp  = req | startup;
	assign res.power_event   = ev;

endmodule

// ===== hw/rtl/compressor_cycle_protection_fsm.sv =====
// Top level of the compressor cycle protection controller.
// Depends on ccp_pkg, ccp_if, ccp_cfg_regs and ccp_step.
//
//   channel   direction  handshake      payload
//   item      in         valid/ready    mode, temperature, sensor_fault
//   result    out        valid/ready    compressor_on, ctrl_state, request_temp,
//                                       power_event
//   cfg       in         cfg_we only    cfg_idx, cfg_data
//
// Each transaction is registered on entry and evaluated from the input
// register, landing in the result register when the result side can take it,
// where it is offered. One transaction is accepted per cycle unless the
// result side stalls; the limit is the single state update.
// Reset puts the controller in ready with the timer at zero and the start-up
// request armed. A stalled result holds the result register and, through it,
// the input register; the input side stalls only when both are full.
module compressor_cycle_protection_fsm
	import ccp_pkg::*;
#(
	parameter int TIMER_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ccp_item_if.sink              item,
	ccp_result_if.source          result
);

	cfg_t                   cfg;
	ctrl_st_t               st_q;
	ctrl_st_t               nxt_st;
	logic [TIMER_WIDTH-1:0] ticks_q;
	logic [TIMER_WIDTH-1:0] nxt_ticks;
	logic                   startup_q;
	logic                   valid_s1;
	item_t                  item_s1;
	logic                   valid_s2;
	result_t                res_nxt;
	result_t                res_s2;
	logic                   adv;

	ccp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	ccp_step #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_step (
		.st        (st_q),
		.ticks     (ticks_q),
		.startup   (startup_q),
		.item      (item_s1),
		.cfg       (cfg),
		.nxt_st    (nxt_st),
		.nxt_ticks (nxt_ticks),
		.res       (res_nxt)
	);

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			st_q      <= S_READY;
			ticks_q   <= '0;
			startup_q <= 1'b1;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				valid_s2  <= 1'b1;
				st_q      <= nxt_st;
				ticks_q   <= nxt_ticks;
				startup_q <= 1'b0;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.mode         <= item.mode;
			item_s1.temperature  <= item.temperature;
			item_s1.sensor_fault <= item.sensor_fault;
		end
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid         = valid_s2;
	assign result.compressor_on = res_s2.compressor_on;
	assign result.ctrl_state    = res_s2.ctrl_state;
	assign result.request_temp  = res_s2.request_temp;
	assign result.power_event   = res_s2.power_event;

endmodule
